// ===== hdl/nmea_gga_pkg.sv =====
package nmea_gga_pkg;

   localparam int LINE_BYTES = 128;
   localparam int LAT_CHARS  = 16;
   localparam int LON_CHARS  = 16;

   localparam int LC_W    = $clog2(LINE_BYTES);
   localparam int LAT_IW  = (LAT_CHARS > 1) ? $clog2(LAT_CHARS) : 1;
   localparam int LON_IW  = (LON_CHARS > 1) ? $clog2(LON_CHARS) : 1;
   localparam int LAT_LW  = $clog2(LAT_CHARS + 1);
   localparam int LON_LW  = $clog2(LON_CHARS + 1);
   localparam int MAX_CH  = (LAT_CHARS > LON_CHARS) ? LAT_CHARS : LON_CHARS;
   localparam int IDX_W   = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;

   localparam logic [2:0] PAT_LEN   = 3'd6;
   localparam logic [2:0] TOK_MAX   = 3'd6;
   localparam logic [2:0] TOK_LAT   = 3'd3;
   localparam logic [2:0] TOK_LON   = 3'd5;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic SEL_LAT = 1'b0;
   localparam logic SEL_LON = 1'b1;

   typedef struct packed {
      logic take;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic start_emit;
      logic emit_last;
      logic slot_free;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   function automatic logic [7:0] pattern_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h24;
         3'd1: ch = 8'h47;
         3'd2: ch = 8'h50;
         3'd3: ch = 8'h47;
         3'd4: ch = 8'h47;
         3'd5: ch = 8'h41;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/nmea_gga_ctrl.sv =====
module nmea_gga_ctrl
   import nmea_gga_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd.take = 1'b0;
      cmd.emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
            if (req_valid && status.start_emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = status.slot_free;
            if (status.slot_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/nmea_gga_dp.sv =====
module nmea_gga_dp
   import nmea_gga_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    req_rx_byte,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_field_select,
   output logic [3:0]    rsp_char_index,
   output logic [7:0]    rsp_char_value,
   output logic          rsp_last
);

   // line state
   logic [LC_W-1:0]   line_count_ff, line_count_in;
   logic [2:0]        match_ff, match_in;
   logic              matched_ff, matched_in;
   logic              ended_ff, ended_in;
   logic [2:0]        tok_ff, tok_in;
   logic              inside_ff, inside_in;
   logic [LAT_LW-1:0] lat_len_ff, lat_len_in;
   logic [LON_LW-1:0] lon_len_ff, lon_len_in;
   logic [7:0]        lat_mem_ff [LAT_CHARS];
   logic [7:0]        lon_mem_ff [LON_CHARS];
   logic              lat_we, lon_we;

   // emission pointer and output word
   logic              sel_ff, sel_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic              fsel_ff, fsel_in;
   logic [3:0]        cidx_ff, cidx_in;
   logic [7:0]        cval_ff, cval_in;
   logic              last_ff, last_in;

   logic [2:0]  tok_scan;
   logic        overlong, is_nl, start_emit;
   logic        lat_end, lon_end, emit_last;
   logic [7:0]  cur_char;

   assign overlong = (line_count_ff == LC_W'(LINE_BYTES - 1));
   assign is_nl    = (req_rx_byte == CH_NL);

   // byte scan
   always_comb begin
      match_in   = match_ff;
      matched_in = matched_ff;
      ended_in   = ended_ff;
      tok_in     = tok_ff;
      inside_in  = inside_ff;
      lat_len_in = lat_len_ff;
      lon_len_in = lon_len_ff;
      lat_we     = 1'b0;
      lon_we     = 1'b0;
      tok_scan   = tok_ff;
      if (!ended_ff) begin
         if (req_rx_byte == CH_NUL) begin
            ended_in = 1'b1;
         end else begin
            if (match_ff < PAT_LEN && req_rx_byte == pattern_char(match_ff)) begin
               if (match_ff == PAT_LEN - 3'd1) begin
                  matched_in = 1'b1;
                  match_in = 3'd0;
               end else begin
                  match_in = match_ff + 3'd1;
               end
            end else begin
               match_in = (req_rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
            end
            if (req_rx_byte == CH_COMMA) begin
               inside_in = 1'b0;
            end else begin
               if (!inside_ff && tok_ff < TOK_MAX) begin
                  tok_scan = tok_ff + 3'd1;
               end
               inside_in = 1'b1;
               tok_in = tok_scan;
               if (tok_scan == TOK_LAT && lat_len_ff < LAT_LW'(LAT_CHARS)) begin
                  lat_we = 1'b1;
                  lat_len_in = lat_len_ff + LAT_LW'(1);
               end else if (tok_scan == TOK_LON && lon_len_ff < LON_LW'(LON_CHARS)) begin
                  lon_we = 1'b1;
                  lon_len_in = lon_len_ff + LON_LW'(1);
               end
            end
         end
      end
   end

   assign start_emit = !overlong && is_nl && matched_in &&
                       (lat_len_in != '0 || lon_len_in != '0);

   // emission
   assign lat_end   = (sel_ff == SEL_LAT) && (LAT_LW'(idx_ff) + LAT_LW'(1) == lat_len_ff);
   assign lon_end   = (sel_ff == SEL_LON) && (LON_LW'(idx_ff) + LON_LW'(1) == lon_len_ff);
   assign emit_last = lon_end || (lat_end && lon_len_ff == '0);
   assign cur_char  = (sel_ff == SEL_LON) ? lon_mem_ff[idx_ff[LON_IW-1:0]]
                                          : lat_mem_ff[idx_ff[LAT_IW-1:0]];

   always_comb begin
      sel_in   = sel_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      fsel_in  = fsel_ff;
      cidx_in  = cidx_ff;
      cval_in  = cval_ff;
      last_in  = last_ff;
      if (cmd.take && start_emit) begin
         sel_in = (lat_len_in == '0) ? SEL_LON : SEL_LAT;
         idx_in = '0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         fsel_in  = sel_ff;
         cidx_in  = 4'(idx_ff);
         cval_in  = cur_char;
         last_in  = emit_last;
         if (lat_end) begin
            sel_in = SEL_LON;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.take && (overlong || (is_nl && !start_emit))) ||
          (cmd.emit && emit_last)) begin
         line_count_ff <= '0;
         match_ff      <= '0;
         matched_ff    <= 1'b0;
         ended_ff      <= 1'b0;
         tok_ff        <= '0;
         inside_ff     <= 1'b0;
         lat_len_ff    <= '0;
         lon_len_ff    <= '0;
      end else if (cmd.take) begin
         line_count_ff <= line_count_ff + LC_W'(1);
         match_ff      <= match_in;
         matched_ff    <= matched_in;
         ended_ff      <= ended_in;
         tok_ff        <= tok_in;
         inside_ff     <= inside_in;
         lat_len_ff    <= lat_len_in;
         lon_len_ff    <= lon_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      idx_ff  <= idx_in;
      fsel_ff <= fsel_in;
      cidx_ff <= cidx_in;
      cval_ff <= cval_in;
      last_ff <= last_in;
      if (cmd.take && !overlong && lat_we) begin
         lat_mem_ff[lat_len_ff[LAT_IW-1:0]] <= req_rx_byte;
      end
      if (cmd.take && !overlong && lon_we) begin
         lon_mem_ff[lon_len_ff[LON_IW-1:0]] <= req_rx_byte;
      end
   end

   assign status.start_emit = start_emit;
   assign status.emit_last  = emit_last;
   assign status.slot_free  = !valid_ff || rsp_ready;

   assign rsp_valid        = valid_ff;
   assign rsp_field_select = fsel_ff;
   assign rsp_char_index   = cidx_ff;
   assign rsp_char_value   = cval_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== hdl/nmea_gga_position_extractor_top.sv =====
// order: a taken newline of a matching line moves the controller to ST_EMIT,
// which loads the first character into the output word register when free
// throughput: one byte per cycle while a line arrives; a completing line then
// holds req_ready low while its characters (up to 32) are emitted
// reset: synchronous, clears the line state, the controller and rsp_valid
module nmea_gga_position_extractor_top
   import nmea_gga_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_field_select,
   output logic [3:0] rsp_char_index,
   output logic [7:0] rsp_char_value,
   output logic       rsp_last
);

   dp_cmd_type    cmd;
   dp_status_type status;

   nmea_gga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nmea_gga_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_select (rsp_field_select),
      .rsp_char_index   (rsp_char_index),
      .rsp_char_value   (rsp_char_value),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== hdl/nmea_gga_chk.sv =====
module nmea_gga_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_field_select,
   input logic [3:0] rsp_char_index,
   input logic [7:0] rsp_char_value,
   input logic       rsp_last
);

   // no output word right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a waiting word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_select) &&
         $stable(rsp_char_index) && $stable(rsp_char_value) && $stable(rsp_last))
      else $error("rsp word dropped while stalled");

   // no byte is taken while a line is still being emitted
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req_ready high during emission");

   // a new line starts at index zero
   a_first_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_char_index == 4'd0)
      else $error("emission did not restart at index zero");

endmodule

bind nmea_gga_position_extractor_top nmea_gga_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_field_select (rsp_field_select),
   .rsp_char_index   (rsp_char_index),
   .rsp_char_value   (rsp_char_value),
   .rsp_last         (rsp_last)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import nmea_gga_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int LONG_HOLD = 400;
   localparam logic [47:0] GGA_TAG = "$GPGGA";

   typedef struct packed {
      logic       sel;
      logic [3:0] idx;
      logic [7:0] val;
      logic       last;
   } char_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_field_select;
   logic [3:0] rsp_char_index;
   logic [7:0] rsp_char_value;
   logic       rsp_last;

   logic [7:0]    pending_bytes[$];
   char_word_type expected_chars[$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         bytes_taken = 0;
   int         words_seen = 0;
   int         drain_at = 0;
   bit         long_hold_done = 0;

   // line tracking
   logic [6:0] line_len;
   logic [2:0] gga_pos;
   logic       gga_seen;
   logic       text_done;
   logic [2:0] field_num;
   logic       in_field;
   logic [7:0] lat_text[LAT_CHARS];
   logic [4:0] lat_len;
   logic [7:0] lon_text[LON_CHARS];
   logic [4:0] lon_len;

   nmea_gga_position_extractor_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_select (rsp_field_select),
      .rsp_char_index   (rsp_char_index),
      .rsp_char_value   (rsp_char_value),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function void clear_line();
      line_len  = '0;
      gga_pos   = '0;
      gga_seen  = 1'b0;
      text_done = 1'b0;
      field_num = '0;
      in_field  = 1'b0;
      lat_len   = '0;
      lon_len   = '0;
   endfunction

   task automatic track_byte(input logic [7:0] rx);
      int total;
      int n;
      if (line_len >= LINE_BYTES - 1) begin
         clear_line();
         return;
      end
      line_len++;
      if (!text_done) begin
         if (rx == CH_NUL) begin
            text_done = 1'b1;
         end else begin
            if (gga_pos < PAT_LEN && rx == GGA_TAG[8 * (5 - gga_pos) +: 8]) begin
               gga_pos++;
               if (gga_pos == PAT_LEN) begin
                  gga_seen = 1'b1;
                  gga_pos  = '0;
               end
            end else begin
               gga_pos = (rx == CH_DOLLAR) ? 3'd1 : 3'd0;
            end
            if (rx == CH_COMMA) begin
               in_field = 1'b0;
            end else begin
               if (!in_field) begin
                  in_field = 1'b1;
                  if (field_num < TOK_MAX) field_num++;
               end
               if (field_num == TOK_LAT && lat_len < LAT_CHARS) begin
                  lat_text[lat_len] = rx;
                  lat_len++;
               end else if (field_num == TOK_LON && lon_len < LON_CHARS) begin
                  lon_text[lon_len] = rx;
                  lon_len++;
               end
            end
         end
      end
      if (rx == CH_NL) begin
         if (gga_seen) begin
            total = lat_len + lon_len;
            n = 0;
            for (int i = 0; i < lat_len; i++) begin
               n++;
               expected_chars.push_back(
                  char_word_type'{SEL_LAT, 4'(i), lat_text[i], n == total});
            end
            for (int i = 0; i < lon_len; i++) begin
               n++;
               expected_chars.push_back(
                  char_word_type'{SEL_LON, 4'(i), lon_text[i], n == total});
            end
         end
         clear_line();
      end
   endtask

   function automatic int draw_wait(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   function void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] field_char();
      logic [7:0] c;
      if ($urandom_range(0, 4) != 0) begin
         c = ($urandom_range(0, 9) == 0) ? 8'h2e : 8'($urandom_range(8'h30, 8'h39));
      end else begin
         do c = 8'($urandom_range(1, 255)); while (c == CH_COMMA || c == CH_NL);
      end
      return c;
   endfunction

   task automatic add_sentence(input bit gga, input bit with_nul);
      int n_fields;
      int len;
      int nul_field;
      n_fields  = $urandom_range(1, 8);
      nul_field = with_nul ? $urandom_range(1, n_fields) : -1;
      if ($urandom_range(0, 5) == 0) add_text("$GPGG");
      else if ($urandom_range(0, 5) == 0) add_text("$");
      add_text(gga ? "$GPGGA" : "$GPRMC");
      for (int f = 1; f <= n_fields; f++) begin
         pending_bytes.push_back(CH_COMMA);
         if ($urandom_range(0, 4) == 0) pending_bytes.push_back(CH_COMMA);
         if ((f == 2 || f == 4) && $urandom_range(0, 7) == 0) len = $urandom_range(14, 20);
         else len = $urandom_range(0, 9);
         for (int i = 0; i < len; i++) begin
            if (f == nul_field && i == len / 2) pending_bytes.push_back(CH_NUL);
            pending_bytes.push_back(field_char());
         end
         if (f == nul_field && len == 0) pending_bytes.push_back(CH_NUL);
      end
      if ($urandom_range(0, 3) == 0) pending_bytes.push_back(CH_COMMA);
      pending_bytes.push_back(CH_NL);
   endtask

   // driver
   always @(posedge clock) begin : drive
      int gap_now;
      int send_mode;
      if (reset) begin
         req_valid <= 1'b0;
         gap_now = 0;
         send_mode = 0;
      end else begin
         if (req_valid && req_ready) begin
            track_byte(req_rx_byte);
            bytes_taken++;
            if (bytes_taken % 48 == 0) send_mode = $urandom_range(0, 2);
            gap_now = draw_wait(send_mode);
         end
         if (req_valid && !req_ready) begin
         end else if (gap_now > 0) begin
            req_valid <= 1'b0;
            gap_now--;
         end else if (bytes_taken == drain_at && expected_chars.size() != 0) begin
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      int hold_now;
      int recv_mode;
      char_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_now = 0;
         recv_mode = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected word, expected none, got sel %0d idx %0d val %02h last %0d",
                        $time, rsp_field_select, rsp_char_index, rsp_char_value, rsp_last);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               check_field("field_select", want.sel, rsp_field_select);
               check_field("char_index", want.idx, rsp_char_index);
               check_field("char_value", want.val, rsp_char_value);
               check_field("last", want.last, rsp_last);
            end
            if (words_seen % 40 == 0) recv_mode = $urandom_range(0, 2);
            hold_now = draw_wait(recv_mode);
            if (words_seen >= 50 && !long_hold_done) begin
               hold_now = LONG_HOLD;
               long_hold_done = 1;
            end
         end
         if (hold_now > 0) begin
            rsp_ready <= 1'b0;
            hold_now--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int kind;
      bit long_done;
      long_done = 0;
      clear_line();
      // empty fields, doubled dollar, byte extremes, newline inside longitude
      add_text("$$GPGGA,,t,");
      pending_bytes.push_back(8'hff);
      add_text(",N,,");
      pending_bytes.push_back(8'h01);
      pending_bytes.push_back(CH_NL);
      // zero byte ends the text
      add_text("$GPGGA,t,A");
      pending_bytes.push_back(CH_NUL);
      pending_bytes.push_back(8'h80);
      add_text(",B\n");
      add_text("$GPGGA\n");
      drain_at = pending_bytes.size();
      while (pending_bytes.size() < 380) begin
         kind = $urandom_range(0, 11);
         if (!long_done && pending_bytes.size() > 120) begin
            for (int i = 0; i < LINE_BYTES + 4; i++) pending_bytes.push_back(field_char());
            pending_bytes.push_back(CH_NL);
            long_done = 1;
         end else if (kind <= 6) begin
            add_sentence(1'b1, 1'b0);
         end else if (kind == 7) begin
            add_sentence(1'b0, 1'b0);
         end else if (kind == 8) begin
            add_sentence(1'b1, 1'b1);
         end else if (kind == 9) begin
            add_text("$GPGGA,12");
            pending_bytes.push_back(CH_NL);
         end else begin
            repeat ($urandom_range(1, 20)) pending_bytes.push_back(8'($urandom_range(0, 255)));
            pending_bytes.push_back(CH_NL);
         end
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_valid) @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
